/* rtl/core/blt_pkg.sv */
// ----------------------------------------------------------------------------
// blt_pkg
// shared types and codes of the byte range lock table
// ----------------------------------------------------------------------------
package blt_pkg;

  typedef enum logic [1:0] {
    ACT_TAKE    = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_CHECK   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_CONFLICT = 3'd2,
    ST_FULL     = 3'd3,
    ST_NONE     = 3'd4
  } status_e;

  localparam logic [1:0] KIND_SHARED    = 2'd0;
  localparam logic [1:0] KIND_EXCLUSIVE = 2'd1;

  typedef struct packed {
    logic [63:0] inode;
    logic [15:0] owner;
    logic        excl;
    logic [63:0] start;
    logic [63:0] stop;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic is_take;
    logic is_release;
    logic rd_last;
    logic conflict;
    logic freed;
    logic free_found;
  } stat_t;

endpackage

/* rtl/core/blt_ram.sv */
// ----------------------------------------------------------------------------
// blt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module blt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/blt_dp.sv */
// ----------------------------------------------------------------------------
// blt_dp
// request registers, entry store, valid bits and the sweep compare stage
// ----------------------------------------------------------------------------
module blt_dp #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  blt_pkg::cmd_t cmd_i,
  output blt_pkg::stat_t stat_o,
  input  logic [1:0]    action_i,
  input  logic [63:0]   inode_i,
  input  logic [15:0]   owner_id_i,
  input  logic [1:0]    lock_kind_i,
  input  logic [63:0]   range_start_i,
  input  logic [63:0]   range_length_i
);
  import blt_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_ENTRIES - 1);

  logic [1:0]  action_q;
  logic [1:0]  kind_q;
  entry_t      req_q;

  logic [IW-1:0] rd_idx_q, cmp_idx_q, free_idx_q;
  logic          cmp_v_q;
  logic          conflict_q, freed_q, free_found_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  entry_t      ent;
  logic [EntryW-1:0] rdata;
  logic        ent_v, same_file, same_owner, overlap;
  logic        req_invalid;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q      <= action_i;
      kind_q        <= lock_kind_i;
      req_q.inode   <= inode_i;
      req_q.owner   <= owner_id_i;
      req_q.excl    <= (lock_kind_i == KIND_EXCLUSIVE);
      req_q.start   <= range_start_i;
      req_q.stop    <= (range_length_i != 64'd0) ? range_start_i + range_length_i
                                                 : {64{1'b1}};
    end
  end

  blt_ram #(
    .WIDTH(EntryW),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit),
    .waddr_i(free_idx_q),
    .wdata_i(req_q),
    .re_i   (cmd_i.step),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  assign ent        = entry_t'(rdata);
  assign ent_v      = valid_q[cmp_idx_q];
  assign same_file  = ent.inode == req_q.inode;
  assign same_owner = ent.owner == req_q.owner;
  assign overlap    = (ent.start < req_q.stop) && (req_q.start < ent.stop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q     <= '0;
      cmp_idx_q    <= '0;
      free_idx_q   <= '0;
      cmp_v_q      <= 1'b0;
      conflict_q   <= 1'b0;
      freed_q      <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
    end else begin
      cmp_v_q   <= cmd_i.step;
      cmp_idx_q <= rd_idx_q;
      if (cmd_i.load) begin
        rd_idx_q     <= '0;
        conflict_q   <= 1'b0;
        freed_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else if (cmd_i.step && (rd_idx_q != LastIdx)) begin
        rd_idx_q <= rd_idx_q + IW'(1);
      end
      if (cmp_v_q) begin
        if (ent_v && same_file && !same_owner && overlap && (ent.excl || req_q.excl)) begin
          conflict_q <= 1'b1;
        end
        if (ent_v && same_file && same_owner && (action_q == ACT_RELEASE)) begin
          freed_q            <= 1'b1;
          valid_q[cmp_idx_q] <= 1'b0;
        end
        if (!ent_v && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= cmp_idx_q;
        end
      end
      if (cmd_i.commit) begin
        valid_q[free_idx_q] <= 1'b1;
      end
    end
  end

  always_comb begin
    req_invalid = 1'b0;
    unique case (action_q) inside
      ACT_RELEASE:         req_invalid = 1'b0;
      ACT_TAKE, ACT_CHECK: req_invalid = (kind_q != KIND_SHARED && kind_q != KIND_EXCLUSIVE)
                                         || (req_q.inode == 64'd0);
      default:             req_invalid = 1'b1;
    endcase
  end

  assign stat_o.invalid    = req_invalid;
  assign stat_o.is_take    = action_q == ACT_TAKE;
  assign stat_o.is_release = action_q == ACT_RELEASE;
  assign stat_o.rd_last    = rd_idx_q == LastIdx;
  assign stat_o.conflict   = conflict_q;
  assign stat_o.freed      = freed_q;
  assign stat_o.free_found = free_found_q;

endmodule

/* rtl/core/blt_ctrl.sv */
// ----------------------------------------------------------------------------
// blt_ctrl
// request sequencer: check, sweep, decide, write back and result register
// ----------------------------------------------------------------------------
module blt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [2:0]     status_o,
  output blt_pkg::cmd_t  cmd_o,
  input  blt_pkg::stat_t stat_i
);
  import blt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SWEEP,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e  state_q;
  logic    out_valid_q;
  status_e status_q, result;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (stat_i.invalid) begin
      result = ST_INVALID;
    end else if (stat_i.is_release) begin
      result = stat_i.freed ? ST_OK : ST_NONE;
    end else if (stat_i.conflict) begin
      result = ST_CONFLICT;
    end else if (!stat_i.is_take) begin
      result = ST_OK;
    end else begin
      result = stat_i.free_found ? ST_OK : ST_FULL;
    end
  end

  assign in_stall_o   = state_q != S_IDLE;
  assign cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.step   = state_q == S_SWEEP;
  assign cmd_o.commit = (state_q == S_FINISH) && out_free && !stat_i.invalid
                        && stat_i.is_take && !stat_i.conflict && stat_i.free_found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      if ((state_q == S_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          state_q <= stat_i.invalid ? S_FINISH : S_SWEEP;
        end
        S_SWEEP: begin
          if (stat_i.rd_last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            status_q <= result;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

/* rtl/core/byte_range_lock_table.sv */
// ----------------------------------------------------------------------------
// byte_range_lock_table
// table of byte range locks serving take, release and check requests
//
//   channel   direction  handshake               payload
//   request   in         in_valid_i / in_stall_o  action, inode, owner_id,
//                                                 lock_kind, range_start,
//                                                 range_length
//   result    out        out_valid_o / out_stall_i  status
//
// a request runs check, a sweep of all TABLE_ENTRIES entries through the single
// read port of the entry ram, drain and finish; invalid arguments skip the
// sweep; the next request is taken only after the result of the last one is
// registered, so one request is in flight at a time
// reset clears all valid bits at once, no clearing pass
// a held result stalls the next decision, the result register frees the input
// ----------------------------------------------------------------------------
module byte_range_lock_table #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] inode_i,
  input  logic [15:0] owner_id_i,
  input  logic [1:0]  lock_kind_i,
  input  logic [63:0] range_start_i,
  input  logic [63:0] range_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o
);
  import blt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  blt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  blt_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .inode_i       (inode_i),
    .owner_id_i    (owner_id_i),
    .lock_kind_i   (lock_kind_i),
    .range_start_i (range_start_i),
    .range_length_i(range_length_i)
  );

endmodule
